### src/asod_pkg.sv
// Package: shape kinds, widths and channel payload types for the overlap detector.
`default_nettype none

package asod_pkg;

  localparam int COORD_BITS = 16;
  localparam int IDENT_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;

  typedef enum logic [1:0] {
    KIND_CIRCLE = 2'd0,
    KIND_RECT   = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_LINE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic                         first_shape;
    kind_t                        shape_kind;
    logic [IDENT_BITS-1:0]        shape_ident;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [SIZE_BITS-1:0]         size_a;
    logic [SIZE_BITS-1:0]         size_b;
  } shape_t;

  typedef struct packed {
    logic [IDENT_BITS-1:0] crushed_ident;
    kind_t                 crushed_kind;
  } crush_t;

endpackage

`default_nettype wire

### src/asod_if.sv
// Valid/ready channel interfaces for shape input and overlap results.
`default_nettype none

interface asod_shape_if;
  import asod_pkg::*;
  logic   valid;
  logic   ready;
  shape_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface asod_crush_if;
  import asod_pkg::*;
  logic   valid;
  logic   ready;
  crush_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/adjacent_shape_overlap_detector.sv
// Top level: tests each shape against its predecessor and reports overlaps.
//
// Shapes enter on the shapes channel, one transaction per cycle while shapes.ready is high, and
// each is tested against the shape accepted just before it (circle-circle by squared distance
// against squared radius sum, circle-rectangle in either order by clamping the center into the
// box). An overlap yields one transaction on crushes carrying the earlier shape's ident and kind;
// other pairs, and the first shape of a list, yield nothing. Throughput is one shape per cycle
// unless backpressure holds input; an accepted shape waits in the input register while the
// compare logic (two 17-bit squarers, a 16-bit squarer, an add and a compare) feeds the result
// register, which drives crushes.
// Backpressure on crushes stalls input only once the input register is also occupied.
`default_nettype none

module adjacent_shape_overlap_detector (
  input wire logic    clk,
  input wire logic    rst,
  asod_shape_if.sink   shapes,
  asod_crush_if.source crushes
);
  import asod_pkg::*;

  localparam int DW = COORD_BITS + 2;   // signed differences, exact
  localparam int MW = COORD_BITS + 1;   // magnitude of a difference
  localparam int PW = 2 * MW;           // square of a magnitude
  localparam int RW = 2 * COORD_BITS;   // square of a radius term

  // previous shape, updated on every accepted transaction
  logic   held_valid;
  shape_t held;

  // input register stage
  logic   s1_valid;
  logic   s1_armed;
  shape_t s1_prev;
  shape_t s1_cur;

  // result register
  logic   out_valid;
  crush_t out_data;

  logic stall;
  logic in_fire;

  assign stall   = out_valid && !crushes.ready;
  assign in_fire = shapes.valid && shapes.ready;
  assign shapes.ready = !(s1_valid && stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_fire) begin
      held_valid <= 1'b1;
    end
    if (in_fire) begin
      held <= shapes.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_armed <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
      s1_armed <= held_valid && !shapes.data.first_shape;
    end else if (!stall) begin
      s1_valid <= 1'b0;
      s1_armed <= 1'b0;
    end
    if (in_fire) begin
      s1_prev <= held;
      s1_cur  <= shapes.data;
    end
  end

  // ---- pair test ----
  logic   pair_cc, pair_cr, pair_rc;
  shape_t circ, box;

  assign pair_cc = (s1_prev.shape_kind == KIND_CIRCLE) && (s1_cur.shape_kind == KIND_CIRCLE);
  assign pair_cr = (s1_prev.shape_kind == KIND_CIRCLE) && (s1_cur.shape_kind == KIND_RECT);
  assign pair_rc = (s1_prev.shape_kind == KIND_RECT) && (s1_cur.shape_kind == KIND_CIRCLE);

  assign circ = pair_rc ? s1_cur : s1_prev;
  assign box  = pair_rc ? s1_prev : s1_cur;

  logic signed [DW-1:0] cx, cy, bx, by, bw, bh;
  logic signed [DW-1:0] lo_x, lo_y, hi_x, hi_y, dx, dy;
  logic [MW-1:0]        mag_x, mag_y;
  logic [COORD_BITS-1:0] rad;
  logic [PW-1:0]        sq_x, sq_y;
  logic [PW:0]          dist_sq;
  logic [RW-1:0]        rsq;
  logic                 hit;

  assign cx = {{(DW-COORD_BITS){circ.pos_x[COORD_BITS-1]}}, circ.pos_x};
  assign cy = {{(DW-COORD_BITS){circ.pos_y[COORD_BITS-1]}}, circ.pos_y};
  assign bx = {{(DW-COORD_BITS){box.pos_x[COORD_BITS-1]}}, box.pos_x};
  assign by = {{(DW-COORD_BITS){box.pos_y[COORD_BITS-1]}}, box.pos_y};
  assign bw = {{(DW-SIZE_BITS){1'b0}}, box.size_a};
  assign bh = {{(DW-SIZE_BITS){1'b0}}, box.size_b};

  // distance from center to near edge; for two circles the plain center difference
  assign lo_x = cx - bx;
  assign lo_y = cy - by;
  assign hi_x = lo_x - bw;
  assign hi_y = lo_y - bh;

  always_comb begin
    if (pair_cc || lo_x < 0) begin
      dx = lo_x;
    end else if (hi_x > 0) begin
      dx = hi_x;
    end else begin
      dx = '0;
    end
    if (pair_cc || lo_y < 0) begin
      dy = lo_y;
    end else if (hi_y > 0) begin
      dy = hi_y;
    end else begin
      dy = '0;
    end
  end

  always_comb begin
    logic signed [DW-1:0] ax, ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    mag_x = ax[MW-1:0];
    mag_y = ay[MW-1:0];
  end

  assign rad = pair_cc ? ({1'b0, circ.size_a} + {1'b0, box.size_a})
                       : {1'b0, circ.size_a};

  assign sq_x    = mag_x * mag_x;
  assign sq_y    = mag_y * mag_y;
  assign rsq     = rad * rad;
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign hit     = s1_armed && (pair_cc || pair_cr || pair_rc)
                && (dist_sq <= {{(PW+1-RW){1'b0}}, rsq});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= s1_valid && hit;
    end
    if (!stall && s1_valid && hit) begin
      out_data.crushed_ident <= s1_prev.shape_ident;
      out_data.crushed_kind  <= s1_prev.shape_kind;
    end
  end

  assign crushes.valid = out_valid;
  assign crushes.data  = out_data;

  // ---- checks ----
  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.crushed_kind == KIND_CIRCLE || out_data.crushed_kind == KIND_RECT))
    else $error("result kind is neither circle nor rectangle");

  a_first_disarms: assert property (@(posedge clk) disable iff (rst)
    (in_fire && shapes.data.first_shape) |=> (s1_valid && !s1_armed))
    else $error("first shape of a list was compared");

  a_held_set: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> held_valid)
    else $error("previous shape not kept after transaction");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_armed))
    else $error("result without a compared shape pair");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && stall) |=> (s1_valid && $stable(s1_cur)))
    else $error("input stage overwritten during stall");

endmodule

`default_nettype wire

### tb/tb_adjacent_shape_overlap_detector.sv
// Testbench for the adjacent shape overlap detector: directed table, then random shape lists.
`timescale 1ns / 100ps

module tb_adjacent_shape_overlap_detector;
  import asod_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_SHAPES  = 600;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct {
    shape_t shape;
    bit     pinned;   // expected result typed in below instead of predicted
    bit     hit;
    crush_t res;
  } probe_row_t;

  logic clk;
  logic rst;

  asod_shape_if shapes ();
  asod_crush_if crushes ();

  adjacent_shape_overlap_detector i_dut (
    .clk     (clk),
    .rst     (rst),
    .shapes  (shapes),
    .crushes (crushes)
  );

  // predictor copy of the held shape
  bit     held_valid;
  shape_t held_shape;

  crush_t     pending_crushes[$];
  probe_row_t probe_rows[$];
  int         error_count;
  int         idle_cycles;
  bit         calm_phase;
  bit         drain_done;
  crush_t     crush_want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit circles_touch(longint x1, longint y1, longint r1,
                                       longint x2, longint y2, longint r2);
    longint dx, dy, rs;
    dx = x1 - x2;
    dy = y1 - y2;
    rs = r1 + r2;
    return (dx * dx + dy * dy) <= rs * rs;
  endfunction

  // far corner formed at full width, no wrap
  function automatic bit circle_touches_box(longint cx, longint cy, longint rad,
                                            longint bx, longint by, longint w, longint h);
    longint dx, dy;
    dx = cx - clamp_to(cx, bx, bx + w);
    dy = cy - clamp_to(cy, by, by + h);
    return (dx * dx + dy * dy) <= rad * rad;
  endfunction

  function automatic bit test_against_held(input shape_t s, output crush_t res);
    bit     hit;
    longint nx, ny, na, nb, hx, hy, ha, hb;
    hit = 1'b0;
    nx = $signed(s.pos_x);
    ny = $signed(s.pos_y);
    na = longint'(s.size_a);
    nb = longint'(s.size_b);
    hx = $signed(held_shape.pos_x);
    hy = $signed(held_shape.pos_y);
    ha = longint'(held_shape.size_a);
    hb = longint'(held_shape.size_b);
    if (!s.first_shape && held_valid) begin
      if (held_shape.shape_kind == KIND_CIRCLE && s.shape_kind == KIND_CIRCLE)
        hit = circles_touch(hx, hy, ha, nx, ny, na);
      else if (held_shape.shape_kind == KIND_CIRCLE && s.shape_kind == KIND_RECT)
        hit = circle_touches_box(hx, hy, ha, nx, ny, na, nb);
      else if (held_shape.shape_kind == KIND_RECT && s.shape_kind == KIND_CIRCLE)
        hit = circle_touches_box(nx, ny, na, hx, hy, ha, hb);
    end
    res.crushed_ident = held_shape.shape_ident;
    res.crushed_kind  = held_shape.shape_kind;
    held_valid = 1'b1;
    held_shape = s;
    return hit;
  endfunction

  function automatic shape_t make_shape(bit first, kind_t k, int id, int x, int y,
                                        int a, int b);
    shape_t s;
    s.first_shape = first;
    s.shape_kind  = k;
    s.shape_ident = IDENT_BITS'(id);
    s.pos_x       = COORD_BITS'(x);
    s.pos_y       = COORD_BITS'(y);
    s.size_a      = SIZE_BITS'(a);
    s.size_b      = SIZE_BITS'(b);
    return s;
  endfunction

  task automatic add_row(shape_t s, bit pinned, bit hit, int rid, kind_t rk);
    probe_row_t row;
    row.shape               = s;
    row.pinned              = pinned;
    row.hit                 = hit;
    row.res.crushed_ident   = IDENT_BITS'(rid);
    row.res.crushed_kind    = rk;
    probe_rows.push_back(row);
  endtask

  // clustered around the last shape most of the time so overlaps are frequent
  function automatic shape_t random_shape(shape_t last);
    shape_t s;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 40)      s.shape_kind = KIND_CIRCLE;
    else if (r < 75) s.shape_kind = KIND_RECT;
    else if (r < 87) s.shape_kind = KIND_TEXT;
    else             s.shape_kind = KIND_LINE;
    s.first_shape = ($urandom_range(0, 19) == 0);
    s.shape_ident = IDENT_BITS'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      s.pos_x  = COORD_BITS'(int'($signed(last.pos_x)) + $urandom_range(0, 600) - 300);
      s.pos_y  = COORD_BITS'(int'($signed(last.pos_y)) + $urandom_range(0, 600) - 300);
      s.size_a = SIZE_BITS'($urandom_range(0, 255));
      s.size_b = SIZE_BITS'($urandom_range(0, 255));
    end else begin
      s.pos_x = COORD_BITS'($urandom);
      s.pos_y = COORD_BITS'($urandom);
      if ($urandom_range(0, 1)) begin
        s.size_a = SIZE_BITS'($urandom);
        s.size_b = SIZE_BITS'($urandom);
      end else begin
        s.size_a = SIZE_BITS'($urandom_range(0, 1023));
        s.size_b = SIZE_BITS'($urandom_range(0, 1023));
      end
    end
    return s;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_shape(shape_t s, bit pinned, bit pin_hit, crush_t pin_res);
    int     gap;
    bit     hit;
    crush_t got;
    gap = pick_idle();
    if (gap > 0) begin
      shapes.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    shapes.valid = 1'b1;
    shapes.data  = s;
    do @(posedge clk); while (!shapes.ready);
    hit = test_against_held(s, got);
    if (pinned) begin
      if (pin_hit) pending_crushes.push_back(pin_res);
    end else if (hit) begin
      pending_crushes.push_back(got);
    end
    @(negedge clk);
  endtask

  initial begin
    int     stall_left;
    int     n;
    crushes.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (drain_done) begin
        crushes.ready = 1'b1;
      end else if (stall_left > 0) begin
        crushes.ready = 1'b0;
        stall_left--;
      end else begin
        n = pick_idle();
        if (n == 0) begin
          crushes.ready = 1'b1;
        end else begin
          crushes.ready = 1'b0;
          stall_left    = n - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && crushes.valid && crushes.ready) begin
      if (pending_crushes.size() == 0) begin
        $display("%0t: unexpected crush: expected none, actual ident %h kind %0d",
                 $time, crushes.data.crushed_ident, crushes.data.crushed_kind);
        error_count++;
      end else begin
        crush_want = pending_crushes.pop_front();
        if (crushes.data.crushed_ident !== crush_want.crushed_ident) begin
          $display("%0t: crushed_ident mismatch: expected %h, actual %h",
                   $time, crush_want.crushed_ident, crushes.data.crushed_ident);
          error_count++;
        end
        if (crushes.data.crushed_kind !== crush_want.crushed_kind) begin
          $display("%0t: crushed_kind mismatch: expected %0d, actual %0d",
                   $time, crush_want.crushed_kind, crushes.data.crushed_kind);
          error_count++;
        end
      end
    end
    if ((shapes.valid && shapes.ready) || (crushes.valid && crushes.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, pending_crushes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    shape_t last;
    error_count  = 0;
    idle_cycles  = 0;
    calm_phase   = 1'b0;
    drain_done   = 1'b0;
    held_valid   = 1'b0;
    held_shape   = '0;
    rst          = 1'b1;
    shapes.valid = 1'b0;
    shapes.data  = '0;

    // after reset: nothing held yet
    add_row(make_shape(0, KIND_CIRCLE, 1, 0, 0, 16, 0), 1, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 2, 0, 0, 16, 0), 1, 1, 1, KIND_CIRCLE);
    add_row(make_shape(1, KIND_CIRCLE, 3, 0, 0, 16, 0), 1, 0, 0, KIND_CIRCLE);
    // box at the negative extremes, nearest point (-1,-1)
    add_row(make_shape(0, KIND_RECT, 4, -32768, -32768, 32767, 32767), 1, 1, 3, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 5, 32767, 32767, 32767, 0), 0, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_RECT, 6, 0, 0, 16, 16), 0, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_RECT, 7, 0, 0, 16, 16), 1, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_TEXT, 8, 0, 0, 16, 16), 1, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 9, 0, 0, 100, 0), 1, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_LINE, 10, 0, 0, 100, 100), 1, 0, 0, KIND_CIRCLE);
    // touching circles count, one step further apart does not
    add_row(make_shape(1, KIND_CIRCLE, 11, 0, 0, 16, 0), 1, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 12, 32, 0, 16, 0), 1, 1, 11, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 13, 65, 0, 16, 0), 1, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_RECT, 14, 81, -10, 10, 20), 1, 1, 13, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 15, 85, 0, 0, 0), 1, 1, 14, KIND_RECT);
    // far corner beyond the coordinate range must not wrap
    add_row(make_shape(1, KIND_RECT, 16, 32767, 32767, 32767, 32767), 1, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 17, 32767, 32767, 0, 0), 1, 1, 16, KIND_RECT);
    add_row(make_shape(0, KIND_CIRCLE, 65535, -32768, -32768, 32767, 32767),
            0, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 0, -32768, -32768, 0, 0), 1, 1, 65535, KIND_CIRCLE);
    add_row(make_shape(0, KIND_LINE, 65535, 32767, -1, 32767, 32767), 1, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_TEXT, 23130, -1, 32767, 32767, 32767), 1, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 21845, -40, 20, 30, 0), 0, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_RECT, 43690, -20, 40, 50, 5), 0, 0, 0, KIND_CIRCLE);
    add_row(make_shape(0, KIND_CIRCLE, 4660, 40, 60, 12, 0), 0, 0, 0, KIND_CIRCLE);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (probe_rows[i])
      send_shape(probe_rows[i].shape, probe_rows[i].pinned, probe_rows[i].hit,
                 probe_rows[i].res);

    last = probe_rows[probe_rows.size() - 1].shape;
    for (int i = 0; i < RANDOM_SHAPES; i++) begin
      if (i % 64 == 0) calm_phase = ($urandom_range(0, 3) == 0);
      last = random_shape(last);
      send_shape(last, 1'b0, 1'b0, '0);
    end
    shapes.valid = 1'b0;

    while (pending_crushes.size() != 0) @(posedge clk);
    drain_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
src/asod_pkg.sv
src/asod_if.sv
src/adjacent_shape_overlap_detector.sv
tb/tb_adjacent_shape_overlap_detector.sv
